### sv/assert_macros.svh
// Assertion helpers shared by the scheduler modules.
// In synthesis builds every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is ignored while reset is asserted (active low).
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### sv/aeps_pkg.sv
`default_nettype none

package aeps_pkg;

    // Field widths of the item and result beats.
    localparam int TASK_W   = 8;
    localparam int LEVEL_W  = 3;
    localparam int BASE_W   = 4;
    localparam int CFG_W    = 4;
    localparam int STATUS_W = 2;
    // Width used for level arithmetic; holds any level count up to 16.
    localparam int CALC_W   = 5;

    // Operation codes.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Levels in use after reset.
    localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the input beat
        logic exec;     // perform the queue operation
        logic load;     // move the pending result into the output register
    } t_dp_cmd;

endpackage

`default_nettype wire

### sv/active_expired_priority_scheduler.sv
// Active/expired multilevel priority scheduler.
// The input beat is captured, executed into a pending result and then loaded into
// the output register. A new item is accepted as the pending result is loaded, not
// while executing; a stalled output holds the result pending and stalls the input.
// Reset (synchronous, active low) clears queue pointers, counts and bank select and
// sets levels_in_use to 4; the slot memory is not cleared and needs no clearing pass.
`default_nettype none

module active_expired_priority_scheduler
    import aeps_pkg::*;
#(
    parameter int MAX_LEVELS  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration write channel.
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    // Input channel.
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_opcode,
    input  wire logic [TASK_W-1:0]   i_task_id,
    input  wire logic                i_was_running,
    input  wire logic [LEVEL_W-1:0]  i_current_level,
    input  wire logic [BASE_W-1:0]   i_base_level,
    // Output channel.
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_task_valid,
    output logic      [TASK_W-1:0]   o_task_out,
    output logic      [LEVEL_W-1:0]  o_new_level,
    output logic                     o_went_expired,
    output logic                     o_banks_swapped,
    output logic      [STATUS_W-1:0] o_status
);

    t_dp_cmd cmd;

    // The register write is always taken.
    assign o_cfg_ready = 1'b1;

    aeps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    aeps_dp #(
        .MAX_LEVELS  (MAX_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_task_id       (i_task_id),
        .i_was_running   (i_was_running),
        .i_current_level (i_current_level),
        .i_base_level    (i_base_level),
        .o_task_valid    (o_task_valid),
        .o_task_out      (o_task_out),
        .o_new_level     (o_new_level),
        .o_went_expired  (o_went_expired),
        .o_banks_swapped (o_banks_swapped),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire

### sv/aeps_ram.sv
`default_nettype none

module aeps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### sv/aeps_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module aeps_ctrl
    import aeps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       load;
    logic       in_ready;
    logic       accept;

    // The output register can take a result when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;
    assign load     = (r_state == S_DONE) && out_free;
    assign in_ready = (r_state == S_IDLE) || load;
    assign accept   = i_valid && in_ready;

    assign o_stall = !in_ready;
    assign o_valid = r_out_valid;

    assign o_cmd.capture = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = load;

    // Next-state logic: an execute state, then a done state that hands off the result.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load) begin
                    n_state = accept ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output beat valid flag.
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_RST(a_exec_then_done, i_clk, i_rst_n, r_state == S_EXEC |=> r_state == S_DONE, "execute not followed by done")
    `ASSERT_RST(a_no_accept_busy, i_clk, i_rst_n, (i_valid && !o_stall) |-> (r_state != S_EXEC), "beat accepted while executing")
    `ASSERT_RST(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == S_DONE, "output valid without a result")

endmodule

`default_nettype wire

### sv/aeps_dp.sv
`default_nettype none

`include "assert_macros.svh"

module aeps_dp
    import aeps_pkg::*;
#(
    parameter int MAX_LEVELS  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic                i_opcode,
    input  wire logic [TASK_W-1:0]   i_task_id,
    input  wire logic                i_was_running,
    input  wire logic [LEVEL_W-1:0]  i_current_level,
    input  wire logic [BASE_W-1:0]   i_base_level,
    output logic                     o_task_valid,
    output logic      [TASK_W-1:0]   o_task_out,
    output logic      [LEVEL_W-1:0]  o_new_level,
    output logic                     o_went_expired,
    output logic                     o_banks_swapped,
    output logic      [STATUS_W-1:0] o_status
);

    localparam int NQ    = 2 * MAX_LEVELS;
    localparam int QW    = $clog2(NQ);
    localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = NQ * QUEUE_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam logic [CALC_W-1:0] MAX_LV = CALC_W'(MAX_LEVELS);

    // Queue number of a level within a bank.
    function automatic logic [QW-1:0] f_queue(input logic bank, input logic [LW-1:0] lvl);
        f_queue = (bank ? QW'(MAX_LEVELS) : '0) + QW'(lvl);
    endfunction

    // Ring pointer advance.
    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] pos);
        f_next = (pos == PW'(QUEUE_DEPTH - 1)) ? '0 : pos + PW'(1);
    endfunction

    // Configuration and captured input beat.
    logic [CFG_W-1:0]   r_levels;
    logic               r_op;
    logic [TASK_W-1:0]  r_task;
    logic               r_run;
    logic [LEVEL_W-1:0] r_cur;
    logic [BASE_W-1:0]  r_base;

    // Queue bookkeeping.
    logic [PW-1:0] r_heads  [NQ];
    logic [PW-1:0] r_tails  [NQ];
    logic [CW-1:0] r_counts [NQ];
    logic          r_bank;

    // Pending result between execute and hand-off.
    logic                r_res_valid;
    logic [LEVEL_W-1:0]  r_res_level;
    logic                r_res_exp;
    logic                r_res_swap;
    logic [STATUS_W-1:0] r_res_status;

    logic [CALC_W-1:0]     top;
    logic [CALC_W-1:0]     cur_sat;
    logic [CALC_W-1:0]     base_m1;
    logic [CALC_W-1:0]     reload;
    logic [CALC_W-1:0]     add_lvl;
    logic                  add_exp;
    logic [MAX_LEVELS-1:0] view0;
    logic [MAX_LEVELS-1:0] view1;
    logic [MAX_LEVELS-1:0] eff_view;
    logic                  act_empty;
    logic                  eff_bank;
    logic                  found;
    logic [LW-1:0]         hi_lvl;
    logic [QW-1:0]         q_sel;
    logic [CW-1:0]         cnt;
    logic                  full;
    logic                  add_wr;
    logic                  add_swap;
    logic [PW-1:0]         pos;
    logic [AW-1:0]         ram_addr;
    logic                  ram_we;
    logic                  ram_re;
    logic [TASK_W-1:0]     ram_rdata;
    logic                  is_take;

    assign is_take = (r_op == OP_TAKE);

    // Highest level in use, with the count clamped to 1..MAX_LEVELS.
    always_comb begin
        if (r_levels == '0) begin
            top = '0;
        end else if (CALC_W'(r_levels) > MAX_LV) begin
            top = MAX_LV - CALC_W'(1);
        end else begin
            top = CALC_W'(r_levels) - CALC_W'(1);
        end
    end

    // Target level of an add: preemption drops a level or reloads into expired; others keep theirs.
    always_comb begin
        cur_sat = (CALC_W'(r_cur) > top) ? top : CALC_W'(r_cur);
        base_m1 = (r_base == '0) ? '0 : CALC_W'(r_base) - CALC_W'(1);
        reload  = (base_m1 > top) ? top : base_m1;
        add_exp = r_run && (cur_sat == '0);
        if (add_exp) begin
            add_lvl = reload;
        end else if (r_run) begin
            add_lvl = cur_sat - CALC_W'(1);
        end else begin
            add_lvl = cur_sat;
        end
    end

    // Non-empty levels of each bank, limited to the levels in use.
    always_comb begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            view0[l] = (r_counts[l] != '0) && (CALC_W'(l) <= top);
            view1[l] = (r_counts[MAX_LEVELS + l] != '0) && (CALC_W'(l) <= top);
        end
    end

    // Take: swap when the active bank is empty, then pick the highest level.
    always_comb begin
        act_empty = r_bank ? ~|view1 : ~|view0;
        eff_bank  = r_bank ^ act_empty;
        eff_view  = eff_bank ? view1 : view0;
        found     = |eff_view;
        hi_lvl    = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (eff_view[l]) begin
                hi_lvl = LW'(l);
            end
        end
    end

    // Queue selection and slot address.
    always_comb begin
        if (is_take) begin
            q_sel = f_queue(eff_bank, hi_lvl);
        end else begin
            q_sel = f_queue(r_bank ^ add_exp, add_lvl[LW-1:0]);
        end
        cnt      = r_counts[q_sel];
        full     = (cnt >= CW'(QUEUE_DEPTH));
        add_wr   = !full;
        add_swap = act_empty && !(add_wr && !add_exp);
        pos      = is_take ? r_heads[q_sel] : r_tails[q_sel];
        ram_addr = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(pos);
        ram_we   = i_cmd.exec && !is_take && add_wr;
        ram_re   = i_cmd.exec && is_take && found;
    end

    aeps_ram #(
        .WIDTH (TASK_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (r_task),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (i_cfg_we) begin
            r_levels <= i_cfg_data;
        end
    end

    // Input beat capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_task <= i_task_id;
            r_run  <= i_was_running;
            r_cur  <= i_current_level;
            r_base <= i_base_level;
        end
    end

    // Queue pointers, counts and bank select.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NQ; q++) begin
                r_heads[q]  <= '0;
                r_tails[q]  <= '0;
                r_counts[q] <= '0;
            end
            r_bank <= 1'b0;
        end else if (i_cmd.exec) begin
            if (is_take) begin
                if (found) begin
                    r_heads[q_sel]  <= f_next(r_heads[q_sel]);
                    r_counts[q_sel] <= cnt - CW'(1);
                end
                r_bank <= eff_bank;
            end else begin
                if (add_wr) begin
                    r_tails[q_sel]  <= f_next(r_tails[q_sel]);
                    r_counts[q_sel] <= cnt + CW'(1);
                end
                r_bank <= r_bank ^ add_swap;
            end
        end
    end

    // Pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (is_take) begin
                r_res_valid  <= found;
                r_res_level  <= '0;
                r_res_exp    <= 1'b0;
                r_res_swap   <= act_empty;
                r_res_status <= found ? ST_OK : ST_NONE;
            end else begin
                r_res_valid  <= 1'b0;
                r_res_level  <= add_lvl[LEVEL_W-1:0];
                r_res_exp    <= add_exp;
                r_res_swap   <= add_swap;
                r_res_status <= full ? ST_FULL : ST_OK;
            end
        end
    end

    // Output register; the task comes straight from the slot memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_task_valid    <= r_res_valid;
            o_task_out      <= r_res_valid ? ram_rdata : '0;
            o_new_level     <= r_res_level;
            o_went_expired  <= r_res_exp;
            o_banks_swapped <= r_res_swap;
            o_status        <= r_res_status;
        end
    end

    `ASSERT_RST(a_full_only_add, i_clk, i_rst_n, i_cmd.exec |=> (r_res_status != ST_FULL || r_op == OP_ADD), "full status on a take")
    `ASSERT_RST(a_take_status, i_clk, i_rst_n, (i_cmd.exec && r_op == OP_TAKE) |=> (r_res_valid == (r_res_status == ST_OK)), "take status disagrees with task valid")

endmodule

`default_nettype wire
